// File: design/geneve_option_identity_parser_top_defines.svh
// Assertion macros for the parser's checker file.
`ifndef GENEVE_OPTION_IDENTITY_PARSER_TOP_DEFINES_SVH
`define GENEVE_OPTION_IDENTITY_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define GOP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define GOP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gop_pkg.sv
// Types, constants and helpers shared by the Geneve option identity parser.
package gop_pkg;

  localparam int MAX_OPTIONS = 4;
  localparam int SEEN_W      = $clog2(MAX_OPTIONS + 1);
  localparam int CFG_ADDR_W  = 4;

  localparam logic [8:0] HDR_BYTES = 9'd8;
  localparam logic [8:0] POS_MAX   = 9'd511;

  // Status codes; the walk uses the top code internally while still running.
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_ABSENT    = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_BADHDR    = 2'd3;
  localparam logic [1:0] WALKING      = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_OPTION_CLASS = 2'd0;
  localparam logic [1:0] REG_OPTION_TYPE  = 2'd1;
  localparam logic [1:0] REG_IDENTITY_LEN = 2'd2;
  localparam logic [1:0] REG_MAX_WORDS    = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } gop_in_t;

  typedef struct packed {
    logic [1:0]  parse_status;
    logic [31:0] source_id;
  } gop_out_t;

  typedef struct packed {
    logic [15:0] option_class;
    logic [7:0]  option_type;
    logic [4:0]  identity_len_words;
    logic [5:0]  max_option_words;
  } gop_cfg_t;

  typedef struct packed {
    logic     emit;
    gop_out_t word;
  } gop_step_t;

  // Option header layout: class [28:13], type [12:5], length [4:0].
  function automatic logic header_matches(input logic [28:0] hdr, input gop_cfg_t cfg);
    header_matches = (cfg.identity_len_words != 5'd0) &&
                     (hdr[28:13] == cfg.option_class) &&
                     (hdr[12:5] == cfg.option_type) &&
                     (hdr[4:0] == cfg.identity_len_words);
  endfunction

endpackage

// File: design/gop_cfg_regs.sv
// Configuration registers of the parser behind an APB-style port.
module gop_cfg_regs
  import gop_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output gop_cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite;
  assign reg_index = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.option_class       <= 16'd0;
      cfg.option_type        <= 8'd0;
      cfg.identity_len_words <= 5'd1;
      cfg.max_option_words   <= 6'd63;
    end else if (wr_en) begin
      case (reg_index)
        REG_OPTION_CLASS: cfg.option_class       <= pwdata[15:0];
        REG_OPTION_TYPE:  cfg.option_type        <= pwdata[7:0];
        REG_IDENTITY_LEN: cfg.identity_len_words <= pwdata[4:0];
        REG_MAX_WORDS:    cfg.max_option_words   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_OPTION_CLASS: prdata = {16'd0, cfg.option_class};
      REG_OPTION_TYPE:  prdata = {24'd0, cfg.option_type};
      REG_IDENTITY_LEN: prdata = {27'd0, cfg.identity_len_words};
      REG_MAX_WORDS:    prdata = {26'd0, cfg.max_option_words};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// File: design/gop_walk.sv
// Per-packet parse state and the one-byte update of the header and option walk.
module gop_walk
  import gop_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  gop_in_t   word,
  input  gop_cfg_t  cfg,
  output gop_step_t res
);

  logic [8:0]        byte_position;
  logic [7:0]        option_area_bytes;
  logic [8:0]        next_option_start;
  logic [SEEN_W-1:0] options_seen;
  logic [28:0]       current_option_header;
  logic [31:0]       identity_shift;
  logic [1:0]        walk_outcome;
  logic              reported;

  logic [7:0]        option_area_bytes_next;
  logic [8:0]        next_option_start_next;
  logic [SEEN_W-1:0] options_seen_next;
  logic [28:0]       current_option_header_next;
  logic [31:0]       identity_shift_next;
  logic [1:0]        walk_outcome_next;
  logic              reported_next;

  always_comb begin
    logic [7:0] b;
    logic [8:0] off;
    logic [8:0] d;
    logic [9:0] opt_end;
    logic       emit;
    logic [1:0] status;
    logic [31:0] ident;

    b   = word.data_byte;
    off = byte_position - HDR_BYTES;
    d   = off - next_option_start;
    opt_end = 10'd0;
    emit   = 1'b0;
    status = ST_BADHDR;
    ident  = 32'd0;

    option_area_bytes_next     = option_area_bytes;
    next_option_start_next     = next_option_start;
    options_seen_next          = options_seen;
    current_option_header_next = current_option_header;
    identity_shift_next        = identity_shift;
    walk_outcome_next          = walk_outcome;
    reported_next              = reported;

    if (!reported) begin
      if (byte_position == 9'd0) begin
        if (b[7:6] != 2'd0 || b[5:0] > cfg.max_option_words) begin
          emit = 1'b1;
        end else begin
          option_area_bytes_next = {b[5:0], 2'b00};
          walk_outcome_next      = (b[5:0] != 6'd0) ? WALKING : ST_ABSENT;
        end
      end else if (byte_position >= HDR_BYTES) begin
        if (walk_outcome == WALKING && off >= next_option_start) begin
          if (d == 9'd0) begin
            current_option_header_next = {b, 21'd0};
          end else if (d == 9'd1) begin
            current_option_header_next[20:13] = b;
          end else if (d == 9'd2) begin
            current_option_header_next[12:5] = b;
          end else if (d == 9'd3) begin
            current_option_header_next[4:0] = b[4:0];
            // Option size is the 4-byte header plus its body words.
            opt_end = {1'b0, next_option_start} +
                      {2'b00, 1'b0, b[4:0] + 5'd0, 2'b00} + 10'd4;
            if (opt_end > {2'b00, option_area_bytes}) begin
              walk_outcome_next = ST_MALFORMED;
            end else if (!header_matches(current_option_header_next, cfg)) begin
              next_option_start_next = opt_end[8:0];
              options_seen_next      = options_seen + 1'b1;
              if (options_seen_next >= SEEN_W'(MAX_OPTIONS) ||
                  opt_end >= {2'b00, option_area_bytes}) begin
                walk_outcome_next = ST_ABSENT;
              end
            end
          end else if (d < 9'd8 && header_matches(current_option_header, cfg)) begin
            identity_shift_next = (d == 9'd4) ? {24'd0, b} : {identity_shift[23:0], b};
            if (d == 9'd7) begin
              walk_outcome_next = ST_FOUND;
            end
          end
        end
      end

      // The option area ends on this byte: report what the walk has found.
      if (!emit && byte_position == (HDR_BYTES - 9'd1) + {1'b0, option_area_bytes_next}) begin
        emit   = 1'b1;
        status = (walk_outcome_next == WALKING) ? ST_ABSENT : walk_outcome_next;
        if (status == ST_FOUND) begin
          ident = identity_shift_next;
        end
      end
      if (!emit && word.last_byte) begin
        emit   = 1'b1;
        status = ST_BADHDR;
      end
      if (emit) begin
        reported_next = 1'b1;
      end
    end

    res.emit              = emit;
    res.word.parse_status = status;
    res.word.source_id    = ident;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position         <= 9'd0;
      option_area_bytes     <= 8'd0;
      next_option_start     <= 9'd0;
      options_seen          <= '0;
      current_option_header <= 29'd0;
      identity_shift        <= 32'd0;
      walk_outcome          <= ST_ABSENT;
      reported              <= 1'b0;
    end else if (step) begin
      if (word.last_byte) begin
        byte_position         <= 9'd0;
        option_area_bytes     <= 8'd0;
        next_option_start     <= 9'd0;
        options_seen          <= '0;
        current_option_header <= 29'd0;
        identity_shift        <= 32'd0;
        walk_outcome          <= ST_ABSENT;
        reported              <= 1'b0;
      end else begin
        if (byte_position != POS_MAX) begin
          byte_position <= byte_position + 9'd1;
        end
        option_area_bytes     <= option_area_bytes_next;
        next_option_start     <= next_option_start_next;
        options_seen          <= options_seen_next;
        current_option_header <= current_option_header_next;
        identity_shift        <= identity_shift_next;
        walk_outcome          <= walk_outcome_next;
        reported              <= reported_next;
      end
    end
  end

endmodule

// File: design/geneve_option_identity_parser_top.sv
// Geneve option identity parser: input register, byte walk and result register.
//
// The in channel carries one packet byte per word, starting at byte 0 of the
// Geneve header, with last_byte set on the final byte of the packet. The out
// channel carries at most one word per packet: a parse status and, when the
// identity option was found, its 32-bit big-endian identity.
// Configuration registers sit on the APB-style port and are meant to be
// written between packets; pready is always high.
// Each accepted byte is held in an input register and walked through the
// per-byte update from there; its result, if any, is loaded into the output
// register, which raises out_valid. The block takes one byte every cycle;
// the only limit is the single output register.
// Reset clears the packet state, the pipeline valids and the configuration
// registers to their defaults. While the receiver stalls, bytes that produce
// no result keep flowing; a byte that does produce one waits in the input
// register until the output register is free, and in_ready drops meanwhile.
module geneve_option_identity_parser_top
  import gop_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gop_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gop_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  gop_cfg_t  cfg;
  gop_step_t res;
  logic      s1_valid;
  gop_in_t   s1_word;
  logic      step;

  gop_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gop_walk u_walk (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .word (s1_word),
    .cfg  (cfg),
    .res  (res)
  );

  // A byte moves on unless it has a result and the output register is full and not being read.
  assign step     = s1_valid && (!res.emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_data <= res.word;
    end
  end

endmodule

// File: design/gop_checker.sv
// Port-level checks of the parser and the bind that attaches them.
`include "geneve_option_identity_parser_top_defines.svh"

module gop_checker
  import gop_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input gop_out_t out_data,
  input logic     pready
);

  logic stalled;
  logic not_found;

  assign stalled   = out_valid && !out_ready;
  assign not_found = out_valid && (out_data.parse_status != ST_FOUND);

  `GOP_ASSERT_NXT(a_out_hold, stalled, out_valid, "result word dropped while stalled")
  `GOP_ASSERT_NXT(a_out_stable, stalled, $stable(out_data), "stalled result word changed")
  `GOP_ASSERT_IMP(a_ident_zero, not_found, out_data.source_id == 32'd0, "identity without a match")
  `GOP_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready, "input stalled with an empty output")
  `GOP_ASSERT_IMP(a_reset_empty, $past(rst), !out_valid && pready, "result valid right after reset")

endmodule

bind geneve_option_identity_parser_top gop_checker u_gop_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

// File: tb/tb_geneve_option_identity_parser_top.sv
// Self-checking testbench for the Geneve option identity parser top level.
`timescale 1ns / 1ps

import gop_pkg::*;

// Tracks the parser's packet state, predicts each packet's status word and
// compares it with the words that leave the block.
class identity_scoreboard;
  gop_cfg_t cfg;
  int pos;
  int area_bytes;
  int opt_start;
  int opts_passed;
  logic [28:0] opt_hdr;
  logic [31:0] ident_acc;
  logic [1:0] outcome;
  bit reported_flag;
  gop_out_t expected_q[$];
  int mismatches;
  int checked;
  int status_count[4];

  function new();
    cfg.option_class = 16'd0;
    cfg.option_type = 8'd0;
    cfg.identity_len_words = 5'd1;
    cfg.max_option_words = 6'd63;
    mismatches = 0;
    checked = 0;
    foreach (status_count[i]) status_count[i] = 0;
    clear_packet();
  endfunction

  function void clear_packet();
    pos = 0;
    area_bytes = 0;
    opt_start = 0;
    opts_passed = 0;
    opt_hdr = '0;
    ident_acc = '0;
    outcome = ST_ABSENT;
    reported_flag = 1'b0;
  endfunction

  function void set_register(logic [1:0] idx, logic [31:0] val);
    case (idx)
      REG_OPTION_CLASS: cfg.option_class = val[15:0];
      REG_OPTION_TYPE: cfg.option_type = val[7:0];
      REG_IDENTITY_LEN: cfg.identity_len_words = val[4:0];
      REG_MAX_WORDS: cfg.max_option_words = val[5:0];
      default: ;
    endcase
  endfunction

  function bit identity_option_hit();
    return cfg.identity_len_words != 5'd0 && opt_hdr[28:13] == cfg.option_class &&
           opt_hdr[12:5] == cfg.option_type && opt_hdr[4:0] == cfg.identity_len_words;
  endfunction

  // One byte of the option area, at offset off from its start.
  function void walk_option_byte(int off, logic [7:0] bv);
    int d;
    int size;
    if (outcome != WALKING || off < opt_start) return;
    d = off - opt_start;
    if (d == 0) begin
      opt_hdr = {bv, 21'd0};
    end else if (d == 1) begin
      opt_hdr[20:13] = bv;
    end else if (d == 2) begin
      opt_hdr[12:5] = bv;
    end else if (d == 3) begin
      opt_hdr[4:0] = bv[4:0];
      size = 4 + 4 * opt_hdr[4:0];
      if (opt_start + size > area_bytes) begin
        outcome = ST_MALFORMED;
      end else if (!identity_option_hit()) begin
        opt_start = opt_start + size;
        opts_passed++;
        if (opts_passed >= MAX_OPTIONS || opt_start >= area_bytes) outcome = ST_ABSENT;
      end
    end else if (d < 8 && identity_option_hit()) begin
      ident_acc = (d == 4) ? {24'd0, bv} : {ident_acc[23:0], bv};
      if (d == 7) outcome = ST_FOUND;
    end
  endfunction

  function void note_byte(gop_in_t w);
    logic [7:0] bv;
    int words;
    bit emit;
    logic [1:0] st;
    logic [31:0] id;
    gop_out_t e;
    bv = w.data_byte;
    emit = 1'b0;
    st = ST_BADHDR;
    id = '0;
    if (!reported_flag) begin
      if (pos == 0) begin
        words = bv[5:0];
        if (bv[7:6] != 2'd0 || words > cfg.max_option_words) begin
          emit = 1'b1;
          st = ST_BADHDR;
        end else begin
          area_bytes = words * 4;
          outcome = (area_bytes != 0) ? WALKING : ST_ABSENT;
        end
      end else if (pos >= HDR_BYTES) begin
        walk_option_byte(pos - HDR_BYTES, bv);
      end
      if (!emit && pos == HDR_BYTES - 1 + area_bytes) begin
        emit = 1'b1;
        st = (outcome == WALKING) ? ST_ABSENT : outcome;
        if (st == ST_FOUND) id = ident_acc;
      end
      // A packet that ends before its option area is complete is a bad header.
      if (!emit && w.last_byte) begin
        emit = 1'b1;
        st = ST_BADHDR;
      end
      if (emit) reported_flag = 1'b1;
    end
    if (w.last_byte) clear_packet();
    else if (pos < POS_MAX) pos++;
    if (emit) begin
      e.parse_status = st;
      e.source_id = id;
      expected_q.push_back(e);
    end
  endfunction

  function void check_result(gop_out_t got);
    gop_out_t e;
    if (expected_q.size() == 0) begin
      if (mismatches < 10)
        $display("ERROR: unexpected result word, status %0d identity %h",
                 got.parse_status, got.source_id);
      mismatches++;
      return;
    end
    e = expected_q.pop_front();
    checked++;
    status_count[e.parse_status]++;
    if (got.parse_status !== e.parse_status || got.source_id !== e.source_id) begin
      if (mismatches < 10)
        $display("ERROR: result %0d: expected status %0d identity %h, got status %0d identity %h",
                 checked, e.parse_status, e.source_id, got.parse_status, got.source_id);
      mismatches++;
    end
  endfunction
endclass

module tb_geneve_option_identity_parser_top;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid;
  logic in_ready;
  gop_in_t in_data;
  logic out_valid;
  logic out_ready;
  gop_out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  identity_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  bit hold_started = 1'b0;
  int hold_left = 0;
  int packets_sent = 0;
  int bytes_sent = 0;
  int phase_bytes;
  logic [7:0] pkt_bytes[$];

  geneve_option_identity_parser_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_go && !hold_started) begin
        hold_left = 200;
        hold_started = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  task automatic send_word(input gop_in_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_packet();
    gop_in_t w;
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      w.data_byte = pkt_bytes[i];
      w.last_byte = (i == pkt_bytes.size() - 1);
      send_word(w);
    end
    packets_sent++;
    bytes_sent += pkt_bytes.size();
    phase_bytes += pkt_bytes.size();
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(idx, val);
  endtask

  // Lets every expected word come out, then lets ignored bytes drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Mostly well-formed option lists around the current setting, plus noise,
  // bad versions, overruns and truncated packets.
  task automatic build_packet();
    int kind;
    int nopt;
    int len;
    int words;
    int n;
    int pick;
    logic [15:0] cls;
    logic [7:0] typ;
    logic [7:0] opts[$];
    pkt_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      pkt_bytes.push_back(8'($urandom_range(64, 255)));
      n = $urandom_range(0, 5);
      repeat (n) pkt_bytes.push_back(8'($urandom));
    end else if (kind < 22) begin
      n = $urandom_range(1, 16);
      repeat (n) pkt_bytes.push_back(8'($urandom));
    end else begin
      nopt = $urandom_range(0, 5);
      for (int i = 0; i < nopt; i++) begin
        cls = sb.cfg.option_class;
        typ = sb.cfg.option_type;
        len = sb.cfg.identity_len_words;
        if ($urandom_range(0, 2) != 0) begin
          pick = $urandom_range(0, 3);
          if (pick == 0) begin
            cls = 16'($urandom);
            typ = 8'($urandom);
            len = $urandom_range(0, 3);
          end else if (pick == 1) begin
            len = (len + $urandom_range(1, 3)) % 32;
          end else if (pick == 2) begin
            typ = 8'($urandom);
          end else begin
            cls = 16'($urandom);
          end
        end
        if (opts.size() + 4 + 4 * len > 252) break;
        opts.push_back(cls[15:8]);
        opts.push_back(cls[7:0]);
        opts.push_back(typ);
        opts.push_back({3'($urandom), 5'(len)});
        repeat (4 * len) opts.push_back(8'($urandom));
      end
      words = opts.size() / 4;
      pick = $urandom_range(0, 9);
      if (pick == 0 && words > 0) words--;
      else if (pick == 1) words += $urandom_range(1, 2);
      if (words > 63) words = 63;
      pkt_bytes.push_back({2'b00, 6'(words)});
      repeat (7) pkt_bytes.push_back(8'($urandom));
      for (int i = 0; i < 4 * words; i++)
        pkt_bytes.push_back((i < opts.size()) ? opts[i] : 8'($urandom));
      n = $urandom_range(0, 3);
      repeat (n) pkt_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, pkt_bytes.size());
        while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] cls, input logic [7:0] typ,
                           input logic [4:0] len, input logic [5:0] maxw,
                           input int send_pct, input int recv_pct,
                           input int budget, input bit pressure);
    wait_idle();
    write_reg(REG_OPTION_CLASS, {16'd0, cls});
    write_reg(REG_OPTION_TYPE, {24'd0, typ});
    write_reg(REG_IDENTITY_LEN, {27'd0, len});
    write_reg(REG_MAX_WORDS, {26'd0, maxw});
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    if (pressure) hold_go <= 1'b1;
    phase_bytes = 0;
    while (phase_bytes < budget) begin
      build_packet();
      // The last packet of a phase is cut short so the phase keeps to its budget.
      while (pkt_bytes.size() > budget - phase_bytes) void'(pkt_bytes.pop_back());
      send_packet();
    end
  endtask

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed packets under the reset setting: bad version, a found identity,
    // an empty option area and a truncated header.
    pkt_bytes = '{8'hFF};
    send_packet();
    pkt_bytes = '{8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h00, 8'h00, 8'h00, 8'hE1, 8'hFF, 8'h00, 8'hA5, 8'h5A};
    send_packet();
    pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_packet();
    pkt_bytes = '{8'h01, 8'h00};
    send_packet();

    run_phase(16'hFFFF, 8'hFF, 5'd31, 6'd63, 0, 0, 250, 1'b0);
    run_phase(16'h0000, 8'h00, 5'd1, 6'd0, 62, 0, 30, 1'b0);
    run_phase(16'($urandom), 8'($urandom), 5'd0, 6'd63, 0, 62, 60, 1'b0);
    run_phase(16'($urandom), 8'($urandom), 5'($urandom_range(1, 4)),
              6'($urandom_range(8, 63)), 0, 0, 70, 1'b1);
    run_phase(16'($urandom), 8'($urandom), 5'($urandom_range(1, 4)),
              6'($urandom_range(8, 63)), 62, 0, 70, 1'b0);
    run_phase(16'($urandom), 8'($urandom), 5'($urandom_range(1, 4)),
              6'($urandom_range(8, 63)), 0, 62, 70, 1'b0);
    run_phase(16'($urandom), 8'($urandom), 5'($urandom_range(1, 4)),
              6'($urandom_range(8, 63)), 37, 37, 70, 1'b0);
    wait_idle();

    $display("Sent %0d packets (%0d bytes) over seven register settings and one long hold-off.",
             packets_sent, bytes_sent);
    $display("Checked %0d status words: %0d found, %0d absent, %0d malformed, %0d bad header.",
             sb.checked, sb.status_count[ST_FOUND], sb.status_count[ST_ABSENT],
             sb.status_count[ST_MALFORMED], sb.status_count[ST_BADHDR]);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: geneve_option_identity_parser_top.f
+incdir+design
design/gop_pkg.sv
design/gop_cfg_regs.sv
design/gop_walk.sv
design/geneve_option_identity_parser_top.sv
design/gop_checker.sv
tb/tb_geneve_option_identity_parser_top.sv
